/* hdl/mexp_pkg.sv */
package mexp_pkg;

  // field widths fixed by the interface
  localparam int DATA_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  // default datapath sizes
  localparam int DEF_WIDTH     = 32;
  localparam int DEF_EXP_WIDTH = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd1;

  // reset values of the registers
  localparam logic [DATA_WIDTH-1:0] EXPONENT_RESET = 32'd1;
  localparam logic [DATA_WIDTH-1:0] MODULUS_RESET  = 32'd1;

  // microprogram sizes
  localparam int PC_WIDTH = 4;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_INPUT   = 3'd2,
    C_MOD_ZERO   = 3'd3,
    C_EBIT_CLEAR = 3'd4,
    C_MUL_BUSY   = 3'd5,
    C_MORE_BITS  = 3'd6,
    C_OUT_FULL   = 3'd7
  } cond_t;

  // datapath actions, carried out when the step falls through
  typedef enum logic [3:0] {
    A_NONE    = 4'd0,
    A_LOAD    = 4'd1,
    A_REDUCE  = 4'd2,
    A_WB_BASE = 4'd3,
    A_MUL_RES = 4'd4,
    A_WB_RES  = 4'd5,
    A_MUL_SQR = 4'd6,
    A_WB_SQR  = 4'd7,
    A_EMIT    = 4'd8
  } action_t;

  typedef struct packed {
    cond_t               cond;
    logic [PC_WIDTH-1:0] target;
    action_t             action;
  } ctl_t;

  // step addresses that are jump targets
  localparam logic [PC_WIDTH-1:0] STEP_WAIT = 4'd0;
  localparam logic [PC_WIDTH-1:0] STEP_BIT  = 4'd4;
  localparam logic [PC_WIDTH-1:0] STEP_SQR  = 4'd7;
  localparam logic [PC_WIDTH-1:0] STEP_EMIT = 4'd10;

  // control store
  function automatic ctl_t program_rom(input logic [PC_WIDTH-1:0] pc);
    ctl_t w;
    case (pc)
      4'd0:    w = '{C_NO_INPUT,   STEP_WAIT, A_LOAD};     // take an item
      4'd1:    w = '{C_MOD_ZERO,   STEP_EMIT, A_NONE};     // zero modulus gives 0
      4'd2:    w = '{C_NEVER,      STEP_WAIT, A_REDUCE};   // base mod m
      4'd3:    w = '{C_MUL_BUSY,   4'd3,      A_WB_BASE};
      4'd4:    w = '{C_EBIT_CLEAR, STEP_SQR,  A_NONE};     // test exponent bit
      4'd5:    w = '{C_NEVER,      STEP_WAIT, A_MUL_RES};  // result * base
      4'd6:    w = '{C_MUL_BUSY,   4'd6,      A_WB_RES};
      4'd7:    w = '{C_NEVER,      STEP_WAIT, A_MUL_SQR};  // base * base
      4'd8:    w = '{C_MUL_BUSY,   4'd8,      A_WB_SQR};
      4'd9:    w = '{C_MORE_BITS,  STEP_BIT,  A_NONE};
      4'd10:   w = '{C_OUT_FULL,   STEP_EMIT, A_EMIT};     // hand off result
      4'd11:   w = '{C_ALWAYS,     STEP_WAIT, A_NONE};
      default: w = '{C_ALWAYS,     STEP_WAIT, A_NONE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/mexp_mulmod.sv */
// modular multiply by double-and-add, one modular add per cycle
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH,
  parameter int BW    = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [BW-1:0]    b,
  input  logic [WIDTH-1:0] m,
  output logic             busy,
  output logic [WIDTH-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a_reg;
  logic [BW-1:0]    b_reg;
  logic [CW-1:0]    cnt;
  logic             add_phase;

  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] gap;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] acc_next;

  // (acc + y) mod m, acc and y below m
  always_comb begin
    y   = add_phase ? a_reg : acc;
    gap = m - y;
    sum = {1'b0, acc} + {1'b0, y};
    if (acc >= gap) begin
      acc_next = acc - gap;
    end else begin
      acc_next = sum[WIDTH-1:0];
    end
  end

  // bit scan, most significant multiplier bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      add_phase <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      add_phase <= 1'b0;
      acc       <= '0;
      a_reg     <= a;
      b_reg     <= b;
      cnt       <= CW'(BW);
    end else if (busy) begin
      acc <= acc_next;
      if (!add_phase && b_reg[BW-1]) begin
        add_phase <= 1'b1;
      end else begin
        add_phase <= 1'b0;
        b_reg     <= {b_reg[BW-2:0], 1'b0};
        cnt       <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = acc;

endmodule

/* hdl/modular_exponentiation_top.sv */
// channel   | direction | payload (low bit first)
// ----------+-----------+------------------------------------------
// s_axis    | in        | tdata[31:0] base_value
// m_axis    | out       | tdata[31:0] power_result
// cfg       | in        | cfg_index (0 exponent, 1 modulus), cfg_data
//
// one item at a time; a modular multiply scans a B-bit multiplier,
// B = max(WIDTH, 32); an item costs the
// base reduction plus, per exponent bit, a squaring and, for a set bit, one
// more multiply; a zero modulus skips the multiplies
// the one modular multiplier is shared by all of these
// synchronous reset restores exponent 1 and modulus 1 and empties the output
// a stalled output holds the sequencer at its hand-off step
module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int WIDTH     = DEF_WIDTH,
  parameter int EXP_WIDTH = DEF_EXP_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [DATA_WIDTH-1:0]      s_axis_tdata,   // [31:0] base_value
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [DATA_WIDTH-1:0]      m_axis_tdata,   // [31:0] power_result
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_data
);

  localparam int BW = (WIDTH > DATA_WIDTH) ? WIDTH : DATA_WIDTH;
  localparam int KW = $clog2(EXP_WIDTH + 1);

  logic [DATA_WIDTH-1:0] exponent;
  logic [DATA_WIDTH-1:0] modulus;

  logic [PC_WIDTH-1:0]   pc;
  ctl_t                  ctl;
  logic                  taken;
  logic                  fire;

  logic [WIDTH-1:0]      mod_used;
  logic [EXP_WIDTH-1:0]  exp_used;
  logic [WIDTH-1:0]      result;
  logic [BW-1:0]         base;
  logic [EXP_WIDTH-1:0]  exp_sr;
  logic [KW-1:0]         k;

  logic                  mul_start;
  logic                  mul_busy;
  logic [WIDTH-1:0]      mul_a;
  logic [BW-1:0]         mul_b;
  logic [WIDTH-1:0]      mul_p;
  logic [DATA_WIDTH-1:0] result_out;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXPONENT_RESET;
      modulus  <= MODULUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPONENT: exponent <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // size the registers and the result to the datapath
  always_comb begin
    mod_used   = '0;
    exp_used   = '0;
    result_out = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (i < DATA_WIDTH) begin
        mod_used[i] = modulus[i];
        result_out[i] = result[i];
      end
    end
    for (int i = 0; i < EXP_WIDTH; i++) begin
      if (i < DATA_WIDTH) begin
        exp_used[i] = exponent[i];
      end
    end
  end

  // control word and jump decision
  assign ctl = program_rom(pc);

  always_comb begin
    case (ctl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = !s_axis_tvalid;
      C_MOD_ZERO:   taken = (mod_used == '0);
      C_EBIT_CLEAR: taken = !exp_sr[0];
      C_MUL_BUSY:   taken = mul_busy;
      C_MORE_BITS:  taken = (k != KW'(EXP_WIDTH));
      C_OUT_FULL:   taken = m_axis_tvalid && !m_axis_tready;
      default:      taken = 1'b0;
    endcase
  end

  assign fire = !taken;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else if (taken) begin
      pc <= ctl.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

  assign s_axis_tready = (ctl.action == A_LOAD);

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = base[WIDTH-1:0];
    mul_b     = base;
    case (ctl.action)
      A_REDUCE: begin
        mul_start = 1'b1;
        mul_a     = WIDTH'(1);
        mul_b     = base;
      end
      A_MUL_RES: begin
        mul_start = 1'b1;
        mul_a     = result;
        mul_b     = base;
      end
      A_MUL_SQR: begin
        mul_start = 1'b1;
        mul_a     = base[WIDTH-1:0];
        mul_b     = base;
      end
      default: ;
    endcase
  end

  mexp_mulmod #(
    .WIDTH (WIDTH),
    .BW    (BW)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .m       (mod_used),
    .busy    (mul_busy),
    .product (mul_p)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctl.action)
        A_LOAD: begin
          base   <= BW'(s_axis_tdata);
          result <= (mod_used == '0) ? '0 : WIDTH'(1);
          exp_sr <= exp_used;
          k      <= '0;
        end
        A_WB_BASE: base   <= BW'(mul_p);
        A_WB_RES:  result <= mul_p;
        A_WB_SQR: begin
          base   <= BW'(mul_p);
          exp_sr <= exp_sr >> 1;
          k      <= k + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && ctl.action == A_EMIT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.action == A_EMIT) begin
      m_axis_tdata <= result_out;
    end
  end

endmodule

/* hdl/mexp_checker.sv */
// port-level checks on the exponentiation block
module mexp_checker
  import mexp_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [DATA_WIDTH-1:0]      s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [DATA_WIDTH-1:0]      m_axis_tdata,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input logic [DATA_WIDTH-1:0]      cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: input closes after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open while an item is at work");

  // input only closes through a transfer
  a_close_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input closed without a transfer");

  // a new result appears while the input is closed, then input reopens
  a_result_then_open: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !s_axis_tready ##1 s_axis_tready)
    else $error("result handoff out of sequence");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);
